// ===== rtl/qtbat_pkg.sv =====
package qtbat_pkg;

  localparam int DEF_NUM_STATES  = 256;
  localparam int DEF_NUM_ACTIONS = 8;

  // Fixed field widths of the stream payloads.
  localparam int STATE_W    = 8;
  localparam int ACTION_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // Bits needed to index n entries, never less than one.
  function automatic int addr_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // one step of the clearing pass
    logic accept;  // input transfer this cycle
    logic eval;    // resolve best against the written value
    logic scan;    // issue one rescan read
    logic wb;      // write best entry back and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // last entry of the clearing pass
    logic in_range;   // input state and action are in range
    logic match;      // written action is the current best
    logic scan_last;  // last rescan read is being issued
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

// ===== rtl/qtbat_ram.sv =====
module qtbat_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/qtbat_ctrl.sv =====
module qtbat_ctrl
  import qtbat_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_WB    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.in_range ? S_RD : S_WB;
        end
      end
      S_RD: begin
        // The memories read the best entry and action 0 on their own.
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.match ? S_SCAN : S_WB;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_WB;
      end
      S_WB: begin
        if (status.out_free) begin
          cmd.wb     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/qtbat_dp.sv =====
module qtbat_dp
  import qtbat_pkg::*;
#(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_ACTIONS = DEF_NUM_ACTIONS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   cfg_we,
  input  logic [VALUE_W-1:0]     cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int SW   = addr_width(NUM_STATES);
  localparam int ACTW = addr_width(NUM_ACTIONS);
  localparam int TBL  = NUM_STATES * NUM_ACTIONS;
  localparam int QAW  = addr_width(TBL);
  localparam int SCW  = $clog2(NUM_ACTIONS + 1);
  localparam int QW   = 1 + VALUE_W;
  localparam int BW   = 1 + ACTW + VALUE_W;

  // Input fields.
  logic [STATE_W-1:0]  s_in;
  logic [ACTION_W-1:0] a_in;
  logic [VALUE_W-1:0]  q_in;
  logic [QAW-1:0]      addr_in;

  assign s_in = in_data[STATE_W-1:0];
  assign a_in = in_data[STATE_W+ACTION_W-1:STATE_W];
  assign q_in = in_data[STATE_W+ACTION_W+VALUE_W-1:STATE_W+ACTION_W];

  assign addr_in = QAW'(SW'(s_in)) * QAW'(NUM_ACTIONS) + QAW'(a_in);

  // Registers.
  logic [VALUE_W-1:0] init_value;
  logic [QAW-1:0]     clr_cnt;
  logic [SW-1:0]      s_reg;
  logic [ACTW-1:0]    a_reg;
  logic [VALUE_W-1:0] q_reg;
  logic               range_ok;
  logic [ACTW-1:0]    best_act;
  logic [VALUE_W-1:0] best_val;
  logic [SCW-1:0]     scan_idx;
  logic               pend;

  logic [ACTION_W-1:0] out_act;
  logic [VALUE_W-1:0]  out_val;

  // Memory ports.
  logic           q_we;
  logic [QAW-1:0] q_waddr;
  logic [QW-1:0]  q_wdata;
  logic [QAW-1:0] q_raddr;
  logic [QW-1:0]  q_rdata;
  logic [QAW-1:0] base;

  logic           b_we;
  logic [SW-1:0]  b_waddr;
  logic [BW-1:0]  b_wdata;
  logic [BW-1:0]  b_rdata;
  logic           b_clr_en;

  // Values seen by the evaluate and compare steps.
  logic [VALUE_W-1:0] q_read;
  logic [ACTW-1:0]    ba0;
  logic [VALUE_W-1:0] bv0;

  assign base     = QAW'(s_reg) * QAW'(NUM_ACTIONS);
  assign b_clr_en = ({1'b0, clr_cnt} < (QAW+1)'(NUM_STATES));

  assign q_we    = cmd.clear | (cmd.accept & status.in_range);
  assign q_waddr = cmd.clear ? clr_cnt : addr_in;
  assign q_wdata = cmd.clear ? '0 : {1'b1, q_in};
  assign q_raddr = base + (cmd.scan ? QAW'(scan_idx) : '0);

  assign b_we    = (cmd.clear & b_clr_en) | (cmd.wb & range_ok);
  assign b_waddr = cmd.clear ? clr_cnt[SW-1:0] : s_reg;
  assign b_wdata = cmd.clear ? '0 : {1'b1, best_act, best_val};

  // Unwritten entries read as the configured initial value.
  assign q_read = q_rdata[QW-1] ? q_rdata[VALUE_W-1:0] : init_value;

  // A state with no best yet starts from action 0.
  assign ba0 = b_rdata[BW-1] ? b_rdata[BW-2:VALUE_W] : '0;
  assign bv0 = b_rdata[BW-1] ? b_rdata[VALUE_W-1:0] : q_read;

  assign status.clr_last  = (clr_cnt == QAW'(TBL - 1));
  assign status.in_range  = (32'(s_in) < 32'(NUM_STATES)) &&
                            (32'(a_in) < 32'(NUM_ACTIONS));
  assign status.match     = (ba0 == a_reg);
  assign status.scan_last = (scan_idx == SCW'(NUM_ACTIONS - 1));
  assign status.out_free  = ~out_valid | out_ready;

  qtbat_ram #(
    .WIDTH  (QW),
    .DEPTH  (TBL),
    .ADDR_W (QAW)
  ) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  qtbat_ram #(
    .WIDTH  (BW),
    .DEPTH  (NUM_STATES),
    .ADDR_W (SW)
  ) u_best_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (s_reg),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      init_value <= '0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if (cfg_we) begin
        init_value <= cfg_data;
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.wb) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      pend <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_reg    <= SW'(s_in);
      a_reg    <= ACTW'(a_in);
      q_reg    <= q_in;
      range_ok <= status.in_range;
    end
    if (cmd.eval) begin
      scan_idx <= '0;
      if (status.match) begin
        best_act <= ba0;
        best_val <= q_reg;
      end else if ($signed(q_reg) > $signed(bv0)) begin
        best_act <= a_reg;
        best_val <= q_reg;
      end else begin
        best_act <= ba0;
        best_val <= bv0;
      end
    end else begin
      if (cmd.scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (pend && ($signed(q_read) > $signed(best_val))) begin
        best_act <= ACTW'(scan_idx - 1'b1);
        best_val <= q_read;
      end
    end
    if (cmd.wb) begin
      out_act <= range_ok ? ACTION_W'(best_act) : '0;
      out_val <= range_ok ? best_val : '0;
    end
  end

  assign out_data = {{(OUT_TDATA_W - ACTION_W - VALUE_W){1'b0}}, out_val, out_act};

endmodule

// ===== rtl/q_table_best_action_tracker.sv =====
// Q table with a running best action per state. Each input transfer writes one
// signed Q16.16 value to a (state, action) entry and produces one result: the
// best action of that state after the update and the value held for it. An
// entry never written reads as the initial value register, and a state seen for
// the first time starts with action 0 as its best. Writing the action that is
// currently best rescans every action of the state, one table read per cycle;
// ties never displace the best. A state or action index out of range changes
// nothing and returns zeros. After reset the block clears all NUM_STATES *
// NUM_ACTIONS entries (2048 at the defaults) before it accepts its first item;
// configuration writes are taken while it clears. An ordinary item passes the
// read, evaluate and write-back steps; an item that hits the current best adds
// the rescan and a drain step before write-back, its reads serial through the
// single read port of the Q table memory. One item is in work at a time, and a
// finished result waits in an output register while the next item is taken.
module q_table_best_action_tracker
  import qtbat_pkg::*;
#(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_ACTIONS = DEF_NUM_ACTIONS
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input item stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: state_index[7:0], action_index[10:8], q_value[42:11].
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0: best_action[2:0], best_value[34:3].
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Initial value register write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [VALUE_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  // The register is always writable; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  qtbat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  qtbat_dp #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
